>>> sv/irpwd_pkg.sv
// Shared types and constants of the infrared pulse-distance decoder.
package irpwd_pkg;

   localparam int unsigned OP_W    = 2;
   localparam int unsigned TIME_W  = 16;
   localparam int unsigned TICKS_W = 14;
   localparam int unsigned CMD_W   = 11;
   localparam int unsigned CNT_W   = 4;
   // Thresholds are held one bit wider than a timestamp, since 5*M and 7*M may exceed 16 bits.
   localparam int unsigned THR_W   = TIME_W + 1;

   localparam logic [TICKS_W-1:0] TICKS_RESET = TICKS_W'(16000);

   localparam logic [OP_W-1:0] OP_EDGE    = 2'd0;
   localparam logic [OP_W-1:0] OP_READ    = 2'd1;
   localparam logic [OP_W-1:0] OP_RELEASE = 2'd2;

   typedef logic [OP_W-1:0]    op_type;
   typedef logic [TIME_W-1:0]  time_type;
   typedef logic [TICKS_W-1:0] ticks_type;
   typedef logic [CMD_W-1:0]   cmd_type;

   // Classification of one edge interval.
   typedef struct packed {
      logic start_ok;
      logic zero_ok;
      logic one_ok;
   } class_type;

endpackage

>>> sv/irpwd_if.sv
// Handshake interfaces of the decoder: request, response and register write channels.
interface irpwd_req_if;
   logic                valid;
   logic                ready;
   irpwd_pkg::op_type   operation;
   irpwd_pkg::time_type edge_time;

   modport source (output valid, output operation, output edge_time, input ready);
   modport sink   (input valid, input operation, input edge_time, output ready);
endinterface

interface irpwd_rsp_if;
   logic               valid;
   logic               ready;
   irpwd_pkg::cmd_type read_data;
   logic               ready_res;
   logic               frame_done;
   logic               frame_error;

   modport source (output valid, output read_data, output ready_res, output frame_done,
                   output frame_error, input ready);
   modport sink   (input valid, input read_data, input ready_res, input frame_done,
                   input frame_error, output ready);
endinterface

interface irpwd_csr_if;
   logic                 valid;
   logic                 ready;
   irpwd_pkg::ticks_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

>>> sv/irpwd_classify.sv
// Interval classifier: sorts one edge interval into start, zero bit or one bit.
module irpwd_classify (
   input  irpwd_pkg::ticks_type ticks_per_ms,
   input  irpwd_pkg::time_type  width,
   output irpwd_pkg::class_type cls
);
   import irpwd_pkg::*;

   logic [THR_W-1:0] m_ext;
   logic [THR_W-1:0] three_m;
   logic [THR_W-1:0] five_m;
   logic [THR_W-1:0] seven_m;
   logic [THR_W-1:0] thr_quarter;
   logic [THR_W-1:0] thr_one_half;
   logic [THR_W-1:0] thr_two_half;
   logic [THR_W-1:0] thr_three_half;
   logic [THR_W-1:0] w_ext;

   assign m_ext   = THR_W'(ticks_per_ms);
   assign three_m = (m_ext << 1) + m_ext;
   assign five_m  = (m_ext << 2) + m_ext;
   assign seven_m = (m_ext << 3) - m_ext;

   // Truncating quarter of M and halves of the scaled products.
   assign thr_quarter    = m_ext >> 2;
   assign thr_one_half   = three_m >> 1;
   assign thr_two_half   = five_m >> 1;
   assign thr_three_half = seven_m >> 1;

   assign w_ext = THR_W'(width);

   assign cls.start_ok = (w_ext > thr_two_half) && (w_ext <= thr_three_half);
   assign cls.zero_ok  = (w_ext > thr_quarter) && (w_ext < thr_one_half);
   assign cls.one_ok   = (w_ext >= thr_one_half) && (w_ext < thr_two_half);

endmodule

>>> sv/ir_pulse_width_decoder_core.sv
// Top level of the infrared pulse-distance frame decoder.
//
// Usage: every request beat carries an operation and a falling-edge timestamp.
// An edge capture advances the frame decoder, a read returns the latched
// command (zero unless a frame is complete) and clears it, and a release drops
// the ready flag so that the next frame can be taken. Every request beat gives
// exactly one response beat with the command, the ready flag after the beat and
// the frame done and frame error flags.
// The csr channel writes ticks_per_ms; it is always ready and should be written
// only while no request is in flight.
// A request beat passes through the input register, then the classify-and-update logic
// into the response register. One beat per cycle is sustained while the receiver
// takes every response. When the receiver stalls the response register holds, and the
// input register holds once it too is full; then req.ready falls.
// Reset clears the decoder to wait for a start edge, empties both registers and
// loads ticks_per_ms with 16000.
module ir_pulse_width_decoder_core #(
   parameter int unsigned BITS_PER_FRAME = 11
) (
   input  logic        clock,
   input  logic        reset,
   irpwd_req_if.sink   req,
   irpwd_rsp_if.source rsp,
   irpwd_csr_if.sink   csr
);
   import irpwd_pkg::*;

   localparam logic [1:0] PH_IDLE   = 2'd0;
   localparam logic [1:0] PH_START  = 2'd1;
   localparam logic [1:0] PH_BITS   = 2'd2;
   localparam logic [1:0] PH_UNUSED = 2'd3;

   localparam logic [CNT_W:0] FRAME_LEN = (CNT_W+1)'(BITS_PER_FRAME);

   // Configuration
   ticks_type ticks_ff;

   // Input register
   logic     in_valid_ff;
   op_type   in_op_ff;
   time_type in_time_ff;

   // Decoder state
   logic [1:0]       phase_ff,    phase_in;
   logic [CNT_W-1:0] bit_count_ff, bit_count_in;
   time_type         last_edge_ff, last_edge_in;
   cmd_type          command_ff,  command_in;
   logic             ready_flag_ff, ready_flag_in;

   // Response register
   logic    out_valid_ff;
   cmd_type out_data_ff,  out_data_in;
   logic    out_done_ff,  out_done_in;
   logic    out_error_ff, out_error_in;

   logic       advance;
   logic       accept;
   time_type   width;
   class_type  cls;
   logic [CNT_W:0] next_count;

   assign advance   = !out_valid_ff || rsp.ready;
   assign req.ready = !in_valid_ff || advance;
   assign accept    = req.valid && req.ready;
   assign csr.ready = 1'b1;

   assign width      = in_time_ff - last_edge_ff;
   assign next_count = {1'b0, bit_count_ff} + (CNT_W+1)'(1);

   irpwd_classify u_classify (
      .ticks_per_ms (ticks_ff),
      .width        (width),
      .cls          (cls)
   );

   always_comb begin
      phase_in      = phase_ff;
      bit_count_in  = bit_count_ff;
      last_edge_in  = last_edge_ff;
      command_in    = command_ff;
      ready_flag_in = ready_flag_ff;
      out_data_in   = '0;
      out_done_in   = 1'b0;
      out_error_in  = 1'b0;
      case (in_op_ff)
         OP_EDGE: begin
            if (!ready_flag_ff) begin
               case (phase_ff)
                  PH_START: begin
                     if (cls.start_ok) begin
                        last_edge_in = in_time_ff;
                        bit_count_in = '0;
                        command_in   = '0;
                        phase_in     = PH_BITS;
                     end else begin
                        out_error_in = 1'b1;
                        phase_in     = PH_IDLE;
                     end
                  end
                  PH_BITS: begin
                     if (cls.zero_ok || cls.one_ok) begin
                        // Positions past the command width shift out and are dropped.
                        if (cls.one_ok) begin
                           command_in = command_ff | (CMD_W'(1) << bit_count_ff);
                        end
                        last_edge_in = in_time_ff;
                        if (next_count >= FRAME_LEN) begin
                           bit_count_in  = '0;
                           ready_flag_in = 1'b1;
                           out_done_in   = 1'b1;
                           phase_in      = PH_IDLE;
                        end else begin
                           bit_count_in = next_count[CNT_W-1:0];
                        end
                     end else begin
                        out_error_in = 1'b1;
                        phase_in     = PH_IDLE;
                     end
                  end
                  default: begin
                     // The first edge only marks the time.
                     last_edge_in = in_time_ff;
                     phase_in     = PH_START;
                  end
               endcase
            end
         end
         OP_READ: begin
            if (ready_flag_ff) begin
               out_data_in = command_ff;
               command_in  = '0;
            end
         end
         OP_RELEASE: begin
            ready_flag_in = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff      <= TICKS_RESET;
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         phase_ff      <= PH_IDLE;
         bit_count_ff  <= '0;
         last_edge_ff  <= '0;
         command_ff    <= '0;
         ready_flag_ff <= 1'b0;
      end else begin
         if (csr.valid) begin
            ticks_ff <= csr.data;
         end
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (advance && in_valid_ff) begin
            phase_ff      <= phase_in;
            bit_count_ff  <= bit_count_in;
            last_edge_ff  <= last_edge_in;
            command_ff    <= command_in;
            ready_flag_ff <= ready_flag_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_op_ff   <= req.operation;
         in_time_ff <= req.edge_time;
      end
      if (advance && in_valid_ff) begin
         out_data_ff  <= out_data_in;
         out_done_ff  <= out_done_in;
         out_error_ff <= out_error_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.read_data   = out_data_ff;
   assign rsp.ready_res   = ready_flag_ff;
   assign rsp.frame_done  = out_done_ff;
   assign rsp.frame_error = out_error_ff;

`ifndef SYNTH
   a_done_excludes_error: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !(out_done_ff && out_error_ff))
      else $error("frame done and frame error in the same beat");

   a_done_sets_ready: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_done_ff) |-> ready_flag_ff)
      else $error("completed frame without the ready flag");

   a_data_needs_ready: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && (out_data_ff != '0)) |-> ready_flag_ff)
      else $error("command returned while not ready");

   a_phase_legal: assert property (@(posedge clock) disable iff (reset)
      phase_ff != PH_UNUSED)
      else $error("decoder phase took the unused code");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      {1'b0, bit_count_ff} < FRAME_LEN)
      else $error("bit count reached the frame length");
`endif

endmodule

>>> dv/ir_pulse_width_decoder_core_tb.sv
`timescale 1ns / 1ps
// Self-checking bench for the IR pulse-distance decoder: a directed table, then random frames.
module ir_pulse_width_decoder_core_tb;
   import irpwd_pkg::*;

   localparam int unsigned FRAME_BITS   = 11;
   localparam int unsigned DIRECTED_N   = 25;
   localparam int unsigned PHASE_N      = 8;
   localparam int unsigned PHASE_ITEMS  = 115;
   localparam int unsigned QUIET_LIMIT  = 2000;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam op_type      OP_UNUSED    = 2'd3;

   typedef enum logic [1:0] {DEC_IDLE, DEC_ARMED, DEC_BITS} dec_phase_type;
   typedef enum int {SPAN_START, SPAN_ZERO, SPAN_ONE, SPAN_BAD_START, SPAN_BAD_BIT}
      span_kind_type;

   typedef struct packed {
      cmd_type read_data;
      logic    ready_res;
      logic    frame_done;
      logic    frame_error;
   } decode_result_type;

   typedef struct {
      op_type            op;
      time_type          stamp;
      bit                fixed;
      decode_result_type want;
   } stim_row_type;

   localparam decode_result_type RES_QUIET = '0;
   localparam decode_result_type RES_ABORT = '{read_data: '0, ready_res: 1'b0,
                                               frame_done: 1'b0, frame_error: 1'b1};
   localparam decode_result_type RES_HELD  = '{read_data: '0, ready_res: 1'b1,
                                               frame_done: 1'b0, frame_error: 1'b0};
   localparam decode_result_type RES_DONE  = '{read_data: '0, ready_res: 1'b1,
                                               frame_done: 1'b1, frame_error: 1'b0};

   // Rows marked fixed carry a hand-written expectation; the rest use the decoder model below.
   // The frame starts at 16'hF000 and wraps; its bits read 1452 LSB first.
   stim_row_type directed_rows [DIRECTED_N] = '{
      '{OP_READ,    16'h0000, 1'b1, RES_QUIET},
      '{OP_UNUSED,  16'hFFFF, 1'b1, RES_QUIET},
      '{OP_RELEASE, 16'h0000, 1'b1, RES_QUIET},
      '{OP_EDGE,    16'h1000, 1'b1, RES_QUIET},
      '{OP_EDGE,    16'h1064, 1'b1, RES_ABORT},
      '{OP_EDGE,    16'hF000, 1'b1, RES_QUIET},
      '{OP_EDGE,    16'hCAC0, 1'b0, RES_QUIET},
      '{OP_EDGE,    16'hDA61, 1'b0, RES_QUIET},
      '{OP_EDGE,    16'h3820, 1'b0, RES_QUIET},
      '{OP_EDGE,    16'h95E0, 1'b0, RES_QUIET},
      '{OP_EDGE,    16'h321F, 1'b0, RES_QUIET},
      '{OP_EDGE,    16'h592F, 1'b0, RES_QUIET},
      '{OP_EDGE,    16'hCE5F, 1'b0, RES_QUIET},
      '{OP_EDGE,    16'hF56F, 1'b0, RES_QUIET},
      '{OP_EDGE,    16'h6A9F, 1'b0, RES_QUIET},
      '{OP_EDGE,    16'hDFCF, 1'b0, RES_QUIET},
      '{OP_EDGE,    16'h06DF, 1'b0, RES_QUIET},
      '{OP_EDGE,    16'h7C0F, 1'b1, RES_DONE},
      '{OP_READ,    16'h0000, 1'b0, RES_QUIET},
      '{OP_READ,    16'hFFFF, 1'b1, RES_HELD},
      '{OP_EDGE,    16'h0000, 1'b1, RES_HELD},
      '{OP_RELEASE, 16'hFFFF, 1'b1, RES_QUIET},
      '{OP_EDGE,    16'h0000, 1'b1, RES_QUIET},
      '{OP_EDGE,    16'h9C40, 1'b1, RES_ABORT},
      '{OP_READ,    16'h0000, 1'b1, RES_QUIET}
   };

   int unsigned cfg_ticks [PHASE_N] = '{16000, 1, 16383, 2, 3, 0, 100, 0};
   int unsigned send_idle [PHASE_N] = '{0, 54, 0, 18, 0, 54, 0, 18};
   int unsigned recv_stall [PHASE_N] = '{0, 0, 54, 18, 0, 0, 54, 18};

   logic clock;
   logic reset;

   irpwd_req_if req_if ();
   irpwd_rsp_if rsp_if ();
   irpwd_csr_if csr_if ();

   ir_pulse_width_decoder_core #(
      .BITS_PER_FRAME(FRAME_BITS)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req  (req_if),
      .rsp  (rsp_if),
      .csr  (csr_if)
   );

   // Decoder model state.
   int unsigned   ticks_q;
   dec_phase_type phase_q;
   int unsigned   bit_cnt_q;
   time_type      last_stamp_q;
   cmd_type       cmd_q;
   logic          ready_flag_q;

   decode_result_type decoded_q [$];
   int unsigned       send_idle_pct;
   int unsigned       recv_stall_pct;
   int unsigned       live_items;
   int unsigned       quiet_cycles = 0;
   int                error_count = 0;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic decode_result_type predict_decode(op_type op, time_type stamp);
      decode_result_type res;
      time_type          span;
      int unsigned       w;
      int unsigned       m;
      res  = '0;
      m    = ticks_q;
      span = stamp - last_stamp_q;
      w    = span;
      case (op)
         OP_EDGE: begin
            if (!ready_flag_q) begin
               case (phase_q)
                  DEC_ARMED: begin
                     if (w > 5 * m / 2 && w <= 7 * m / 2) begin
                        last_stamp_q = stamp;
                        bit_cnt_q    = 0;
                        cmd_q        = '0;
                        phase_q      = DEC_BITS;
                     end else begin
                        res.frame_error = 1'b1;
                        phase_q         = DEC_IDLE;
                     end
                  end
                  DEC_BITS: begin
                     if (w <= m / 4 || w >= 5 * m / 2) begin
                        res.frame_error = 1'b1;
                        phase_q         = DEC_IDLE;
                     end else begin
                        if (w >= 3 * m / 2 && bit_cnt_q < CMD_W) cmd_q[bit_cnt_q] = 1'b1;
                        last_stamp_q = stamp;
                        if (bit_cnt_q + 1 >= FRAME_BITS) begin
                           bit_cnt_q      = 0;
                           ready_flag_q   = 1'b1;
                           res.frame_done = 1'b1;
                           phase_q        = DEC_IDLE;
                        end else begin
                           bit_cnt_q = bit_cnt_q + 1;
                        end
                     end
                  end
                  default: begin
                     last_stamp_q = stamp;
                     phase_q      = DEC_ARMED;
                  end
               endcase
            end
         end
         OP_READ: begin
            if (ready_flag_q) begin
               res.read_data = cmd_q;
               cmd_q         = '0;
            end
         end
         OP_RELEASE: ready_flag_q = 1'b0;
         default: ;
      endcase
      res.ready_res = ready_flag_q;
      return res;
   endfunction

   // Draws an interval of the given class; boundaries are favoured.
   function automatic int unsigned pick_span(span_kind_type kind, int unsigned m);
      int unsigned lo;
      int unsigned hi;
      bit          upper;
      upper = $urandom_range(1);
      case (kind)
         SPAN_START: begin
            lo = 5 * m / 2 + 1;
            hi = 7 * m / 2;
         end
         SPAN_ZERO: begin
            lo = m / 4 + 1;
            hi = 3 * m / 2 - 1;
            // At one tick per ms no interval is a zero bit, so a one bit is sent instead.
            if (hi < lo) begin
               lo = 3 * m / 2;
               hi = 5 * m / 2 - 1;
            end
         end
         SPAN_ONE: begin
            lo = 3 * m / 2;
            hi = 5 * m / 2 - 1;
         end
         SPAN_BAD_START: begin
            lo = upper ? 7 * m / 2 + 1 : 0;
            hi = upper ? 65535 : 5 * m / 2;
         end
         default: begin
            lo = upper ? 5 * m / 2 : 0;
            hi = upper ? 65535 : m / 4;
         end
      endcase
      case ($urandom_range(3))
         0:       return lo;
         1:       return hi;
         default: return $urandom_range(hi, lo);
      endcase
   endfunction

   task automatic put_req(op_type op, time_type stamp, bit fixed = 1'b0,
                          decode_result_type fixed_want = '0);
      decode_result_type want;
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.operation <= op;
      req_if.edge_time <= stamp;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      // Unused operations and edges while the flag is up leave the decoder untouched.
      if (!(op == OP_UNUSED || (op == OP_EDGE && ready_flag_q))) live_items++;
      want = predict_decode(op, stamp);
      decoded_q.push_back(fixed ? fixed_want : want);
   endtask

   task automatic write_ticks(int unsigned m);
      csr_if.valid <= 1'b1;
      csr_if.data  <= ticks_type'(m);
      do @(posedge clock); while (!(csr_if.valid === 1'b1 && csr_if.ready === 1'b1));
      csr_if.valid <= 1'b0;
      ticks_q = m;
   endtask

   task automatic drain_responses();
      req_if.valid <= 1'b0;
      while (decoded_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic send_frame();
      time_type      t;
      bit            abort;
      span_kind_type kind;
      abort = 1'b0;
      if (ready_flag_q && $urandom_range(99) < 80) put_req(OP_RELEASE, time_type'($urandom));
      t = time_type'($urandom);
      put_req(OP_EDGE, t);
      if ($urandom_range(99) < 8) begin
         t += time_type'(pick_span(SPAN_BAD_START, ticks_q));
         put_req(OP_EDGE, t);
         abort = 1'b1;
      end else begin
         t += time_type'(pick_span(SPAN_START, ticks_q));
         put_req(OP_EDGE, t);
      end
      for (int i = 0; i < FRAME_BITS && !abort; i++) begin
         if ($urandom_range(99) < 3) begin
            kind  = SPAN_BAD_BIT;
            abort = 1'b1;
         end else begin
            kind = $urandom_range(1) ? SPAN_ONE : SPAN_ZERO;
         end
         t += time_type'(pick_span(kind, ticks_q));
         put_req(OP_EDGE, t);
      end
      if ($urandom_range(99) < 90) put_req(OP_READ, time_type'($urandom));
      if ($urandom_range(99) < 20) put_req(OP_READ, time_type'($urandom));
      if ($urandom_range(99) < 65) put_req(OP_RELEASE, time_type'($urandom));
   endtask

   task automatic send_noise();
      repeat ($urandom_range(4, 1)) put_req(op_type'($urandom_range(3)), time_type'($urandom));
   endtask

   always @(posedge clock) begin
      rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   always @(posedge clock) begin : check_rsp
      decode_result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (decoded_q.size() == 0) begin
            $error("response beat with no expectation pending");
            error_count++;
         end else begin
            want = decoded_q.pop_front();
            if (rsp_if.read_data !== want.read_data) begin
               $error("read_data: expected %0d, got %0d", want.read_data, rsp_if.read_data);
               error_count++;
            end
            if (rsp_if.ready_res !== want.ready_res) begin
               $error("ready_res: expected %0b, got %0b", want.ready_res, rsp_if.ready_res);
               error_count++;
            end
            if (rsp_if.frame_done !== want.frame_done) begin
               $error("frame_done: expected %0b, got %0b", want.frame_done, rsp_if.frame_done);
               error_count++;
            end
            if (rsp_if.frame_error !== want.frame_error) begin
               $error("frame_error: expected %0b, got %0b", want.frame_error,
                      rsp_if.frame_error);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_if.valid === 1'b1 && req_if.ready === 1'b1) ||
          (rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) ||
          (csr_if.valid === 1'b1 && csr_if.ready === 1'b1)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[ir_pulse_width_decoder_core] ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned m;
      reset            <= 1'b1;
      req_if.valid     <= 1'b0;
      req_if.operation <= OP_EDGE;
      req_if.edge_time <= '0;
      csr_if.valid     <= 1'b0;
      csr_if.data      <= TICKS_RESET;
      send_idle_pct    = 0;
      recv_stall_pct   = 0;
      ticks_q          = TICKS_RESET;
      phase_q          = DEC_IDLE;
      bit_cnt_q        = 0;
      last_stamp_q     = '0;
      cmd_q            = '0;
      ready_flag_q     = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i]) begin
         put_req(directed_rows[i].op, directed_rows[i].stamp, directed_rows[i].fixed,
                 directed_rows[i].want);
      end
      drain_responses();

      for (int p = 0; p < PHASE_N; p++) begin
         m = (cfg_ticks[p] != 0) ? cfg_ticks[p] : $urandom_range(16383, 1);
         write_ticks(m);
         send_idle_pct  = send_idle[p];
         recv_stall_pct = recv_stall[p];
         live_items     = 0;
         while (live_items < PHASE_ITEMS) begin
            if ($urandom_range(99) < 85) send_frame();
            else send_noise();
         end
         drain_responses();
      end

      if (error_count == 0 && decoded_q.size() == 0) begin
         $display("[ir_pulse_width_decoder_core] OK");
      end else begin
         $display("[ir_pulse_width_decoder_core] ERROR");
      end
      $finish;
   end

endmodule

>>> ir_pulse_width_decoder_core.f
sv/irpwd_pkg.sv
sv/irpwd_if.sv
sv/irpwd_classify.sv
sv/ir_pulse_width_decoder_core.sv
dv/ir_pulse_width_decoder_core_tb.sv
